/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the link table RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define RLT_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// antecedent in one cycle implies consequent in the next
`define RLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

/* rtl/rlt_pkg.sv */
// ---------------------------------------------------------------------------
// rlt_pkg
// Types and constants shared by the reference counted link table
// ---------------------------------------------------------------------------
package rlt_pkg;

   // default sizing
   localparam int DEF_TABLE_DEPTH = 8;
   localparam int DEF_KEY_WIDTH   = 16;

   // fixed field widths of the channels
   localparam int ACTION_W   = 2;
   localparam int KEY_IN_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;
   localparam int USED_OUT_W = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

   // request action codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_INVALID   = 2'd3
   } status_type;

   // operation broadcast to every cell of the row
   typedef struct packed {
      logic add;     // add reference to a matching entry
      logic remove;  // remove reference from a matching entry
      logic append;  // first free cell takes the key with count one
   } cell_cmd_type;

endpackage

/* rtl/rlt_if.sv */
// ---------------------------------------------------------------------------
// rlt_if
// Valid/ready channels for link table requests and responses
// ---------------------------------------------------------------------------

// request word: action and key
interface rlt_req_if;
   logic                         valid;
   logic                         ready;
   logic [rlt_pkg::ACTION_W-1:0] action;
   logic [rlt_pkg::KEY_IN_W-1:0] key;

   modport source (output valid, action, key, input ready);
   modport sink   (input valid, action, key, output ready);
endinterface

// response word: status, count and occupancy
interface rlt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rlt_pkg::STATUS_W-1:0]   status;
   logic [rlt_pkg::COUNT_W-1:0]    ref_count;
   logic [rlt_pkg::USED_OUT_W-1:0] used_entries;

   modport source (output valid, status, ref_count, used_entries, input ready);
   modport sink   (input valid, status, ref_count, used_entries, output ready);
endinterface

/* rtl/rlt_cell.sv */
// ---------------------------------------------------------------------------
// rlt_cell
// One table slot: key, reference count and occupancy, with compare and
// shift-up from the next slot on deletion
// ---------------------------------------------------------------------------
module rlt_cell #(
   parameter int KEY_WIDTH = rlt_pkg::DEF_KEY_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rlt_pkg::cell_cmd_type       cmd,
   input  logic [KEY_WIDTH-1:0]        search_key,
   input  logic                        prev_valid,
   input  logic                        prev_shift,
   input  logic                        next_valid,
   input  logic [KEY_WIDTH-1:0]        next_key,
   input  logic [rlt_pkg::COUNT_W-1:0] next_count,
   output logic                        valid,
   output logic [KEY_WIDTH-1:0]        key,
   output logic [rlt_pkg::COUNT_W-1:0] count,
   output logic                        hit,
   output logic                        shift
);

   logic                        valid_ff, valid_in;
   logic [KEY_WIDTH-1:0]        key_ff, key_in;
   logic [rlt_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        del_here;

   // compare and delete detection
   assign hit      = valid_ff && (key_ff == search_key);
   assign del_here = cmd.remove && hit && (count_ff == rlt_pkg::COUNT_ONE);
   assign shift    = prev_shift || del_here;

   // next slot contents
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      count_in = count_ff;
      priority if (shift) begin
         valid_in = next_valid;
         key_in   = next_key;
         count_in = next_count;
      end else if (cmd.add && hit) begin
         if (count_ff != rlt_pkg::COUNT_MAX) begin
            count_in = count_ff + rlt_pkg::COUNT_ONE;
         end
      end else if (cmd.remove && hit) begin
         count_in = count_ff - rlt_pkg::COUNT_ONE;
      end else if (cmd.append && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         key_in   = search_key;
         count_in = rlt_pkg::COUNT_ONE;
      end else begin
         // slot keeps its contents
      end
   end

   // slot registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         key_ff   <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         key_ff   <= key_in;
         count_ff <= count_in;
      end
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign count = count_ff;

endmodule

/* rtl/refcounted_link_table.sv */
// ---------------------------------------------------------------------------
// refcounted_link_table
// Packed table of nonzero keys with saturating reference counts
// ---------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH slot cells kept packed at the front.
// When a request word is accepted, all cells compare the key at
// once, a hit cell counts up or down, a miss on add lands in the first free
// cell, and a count that reaches zero deletes its slot while the cells
// behind it shift up one place along the row in that same edge. One word
// is accepted per clock as long as the response register is empty or being
// taken; the response appears in the cycle after acceptance. The combinational
// path runs through the key compare and the delete ripple down the row, so
// its length grows with TABLE_DEPTH. Reset empties all slots at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module refcounted_link_table #(
   parameter int TABLE_DEPTH = rlt_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_WIDTH   = rlt_pkg::DEF_KEY_WIDTH
) (
   input logic    clock,
   input logic    reset,
   rlt_req_if.sink   req,
   rlt_rsp_if.source rsp
);

   localparam int USED_W = $clog2(TABLE_DEPTH + 1);

   // row signals
   logic [TABLE_DEPTH-1:0]      valid_vec;
   logic [TABLE_DEPTH-1:0]      hit_vec;
   logic [TABLE_DEPTH-1:0]      shift_vec;
   logic [KEY_WIDTH-1:0]        key_arr   [TABLE_DEPTH];
   logic [rlt_pkg::COUNT_W-1:0] count_arr [TABLE_DEPTH];

   rlt_pkg::cell_cmd_type       cmd;
   logic                        accept;
   logic [KEY_WIDTH-1:0]        key_eff;
   logic                        key_ok;
   logic                        any_hit;
   logic                        full;
   logic                        is_add, is_remove;
   logic                        deleting;
   logic [rlt_pkg::COUNT_W-1:0] hit_count;

   logic [USED_W-1:0]           used_ff, used_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rlt_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [rlt_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [rlt_pkg::USED_OUT_W-1:0] rsp_used_ff, rsp_used_in;

   // handshake
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // key decode
   assign key_eff = KEY_WIDTH'(req.key);
   assign key_ok  = (key_eff != '0);
   assign any_hit = |hit_vec;
   assign full    = valid_vec[TABLE_DEPTH-1];

   // action decode
   always_comb begin
      is_add    = 1'b0;
      is_remove = 1'b0;
      unique case (req.action)
         rlt_pkg::ACT_ADD:    is_add    = 1'b1;
         rlt_pkg::ACT_REMOVE: is_remove = 1'b1;
         default: ;
      endcase
   end

   // count of the matching cell
   always_comb begin
      hit_count = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_count = hit_count | (count_arr[i] & {rlt_pkg::COUNT_W{hit_vec[i]}});
      end
   end

   // command broadcast to the row
   always_comb begin
      cmd.add    = accept && key_ok && is_add;
      cmd.remove = accept && key_ok && is_remove;
      cmd.append = accept && key_ok && is_add && !any_hit && !full;
   end

   assign deleting = cmd.remove && any_hit && (hit_count == rlt_pkg::COUNT_ONE);

   // cell row
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic                        prev_valid, prev_shift, next_valid;
      logic [KEY_WIDTH-1:0]        next_key;
      logic [rlt_pkg::COUNT_W-1:0] next_count;

      if (g == 0) begin : g_first
         assign prev_valid = 1'b1;
         assign prev_shift = 1'b0;
      end else begin : g_mid
         assign prev_valid = valid_vec[g-1];
         assign prev_shift = shift_vec[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_last
         assign next_valid = 1'b0;
         assign next_key   = '0;
         assign next_count = '0;
      end else begin : g_inner
         assign next_valid = valid_vec[g+1];
         assign next_key   = key_arr[g+1];
         assign next_count = count_arr[g+1];
      end

      rlt_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .search_key (key_eff),
         .prev_valid (prev_valid),
         .prev_shift (prev_shift),
         .next_valid (next_valid),
         .next_key   (next_key),
         .next_count (next_count),
         .valid      (valid_vec[g]),
         .key        (key_arr[g]),
         .count      (count_arr[g]),
         .hit        (hit_vec[g]),
         .shift      (shift_vec[g])
      );
   end

   // occupancy after the operation
   always_comb begin
      used_in = used_ff;
      if (cmd.append) begin
         used_in = used_ff + USED_W'(1);
      end else if (deleting) begin
         used_in = used_ff - USED_W'(1);
      end
   end

   // response word
   always_comb begin
      rsp_status_in = rlt_pkg::STAT_DONE;
      rsp_count_in  = '0;
      priority if (!key_ok) begin
         rsp_status_in = rlt_pkg::STAT_INVALID;
      end else if (is_add) begin
         if (any_hit) begin
            rsp_count_in = (hit_count == rlt_pkg::COUNT_MAX) ? hit_count
                                                             : hit_count + rlt_pkg::COUNT_ONE;
         end else if (!full) begin
            rsp_count_in = rlt_pkg::COUNT_ONE;
         end else begin
            rsp_status_in = rlt_pkg::STAT_FULL;
         end
      end else if (!any_hit) begin
         rsp_status_in = rlt_pkg::STAT_NOT_FOUND;
      end else if (is_remove) begin
         rsp_count_in = hit_count - rlt_pkg::COUNT_ONE;
      end else begin
         rsp_count_in = hit_count;
      end
      rsp_used_in = rlt_pkg::USED_OUT_W'(used_in);
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_used_ff   <= rsp_used_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.ref_count    = rsp_count_ff;
   assign rsp.used_entries = rsp_used_ff;

   // checks
   `RLT_ASSERT_ALWAYS(a_hit_unique, clock, reset, $onehot0(hit_vec))
   `RLT_ASSERT_ALWAYS(a_packed, clock, reset, ((valid_vec & (valid_vec + 1'b1)) == '0))
   `RLT_ASSERT_ALWAYS(a_used_matches, clock, reset, ($countones(valid_vec) == int'(used_ff)))
   `RLT_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid_ff)
   `RLT_ASSERT_NEXT(a_full_no_grow, clock, reset, (full && !deleting), full)

endmodule
